// ===== rtl/dcr_pkg.sv =====
// ----------------------------------------------------------------------------
// dcr_pkg
// Shared widths, register indexes, state and control types and the
// toward-zero shift helper for the coefficient requantizer.
// ----------------------------------------------------------------------------
package dcr_pkg;

    // field widths
    localparam int COEF_WIDTH     = 16;
    localparam int ACC_WIDTH      = 40;
    localparam int ERR_WIDTH      = 16;
    localparam int QS_WIDTH       = 16;
    localparam int INV_WIDTH      = 24;
    localparam int OFS_WIDTH      = 9;
    localparam int WGT_WIDTH      = 9;
    localparam int BND_WIDTH      = 17;
    localparam int CFG_DATA_WIDTH = 24;
    localparam int CFG_IDX_WIDTH  = 3;

    // datapath widths of the shared multiply-add unit
    localparam int MA_WIDTH   = COEF_WIDTH + 17;
    localparam int MB_WIDTH   = INV_WIDTH + 1;
    localparam int PROD_WIDTH = MA_WIDTH + MB_WIDTH;
    localparam int SUM_WIDTH  = PROD_WIDTH + 1;
    localparam int CMP_WIDTH  = ((COEF_WIDTH > BND_WIDTH) ? COEF_WIDTH : BND_WIDTH) + 1;
    localparam int SOFS_WIDTH = OFS_WIDTH + 2;

    // register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_QUANT_STEP   = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_INV_STEP     = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_ROUND_OFFSET = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_BLEND_WEIGHT = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_LOWER_BOUND  = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_UPPER_BOUND  = 3'd5;

    // register reset values
    localparam logic [QS_WIDTH-1:0]         QUANT_STEP_RST   = 16'd256;
    localparam logic [INV_WIDTH-1:0]        INV_STEP_RST     = 24'd65536;
    localparam logic [OFS_WIDTH-1:0]        ROUND_OFFSET_RST = 9'd128;
    localparam logic [WGT_WIDTH-1:0]        BLEND_WEIGHT_RST = 9'd256;
    localparam logic signed [BND_WIDTH-1:0] LOWER_BOUND_RST  = -17'sd65535;
    localparam logic signed [BND_WIDTH-1:0] UPPER_BOUND_RST  = 17'sd65535;

    // unity weight in Q1.8
    localparam logic [WGT_WIDTH-1:0] WEIGHT_ONE = 9'd256;

    // fraction bits dropped after each multiply
    localparam logic [4:0] SHIFT_RECIP = 5'd16;
    localparam logic [4:0] SHIFT_Q8    = 5'd8;

    typedef logic signed [SUM_WIDTH-1:0] t_sum;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_MUL4,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic ld_acc;
        logic ld_err;
        logic ld_sum;
        logic test;
        logic ld_out;
    } t_ctrl;

    // arithmetic shift right that truncates toward zero
    function automatic t_sum tz_shr(input t_sum x, input logic [4:0] sh);
        t_sum bias;
        bias = x[SUM_WIDTH-1] ? ((t_sum'(1) <<< sh) - t_sum'(1)) : t_sum'(0);
        return (x + bias) >>> sh;
    endfunction

endpackage

// ===== rtl/dcr_mac.sv =====
// ----------------------------------------------------------------------------
// dcr_mac
// Shared signed multiply-add unit: product of two operands plus an addend.
// ----------------------------------------------------------------------------
module dcr_mac (
    input  logic signed [dcr_pkg::MA_WIDTH-1:0] i_a,
    input  logic signed [dcr_pkg::MB_WIDTH-1:0] i_b,
    input  dcr_pkg::t_sum                       i_addend,
    output dcr_pkg::t_sum                       o_sum
);
    import dcr_pkg::*;

    logic signed [PROD_WIDTH-1:0] prod;

    assign prod  = i_a * i_b;
    assign o_sum = SUM_WIDTH'(prod) + i_addend;

endmodule

// ===== rtl/dct_coef_requantizer_top.sv =====
// ----------------------------------------------------------------------------
// dct_coef_requantizer_top
// Requantizes one signed DCT coefficient per transfer, with blending and a
// saturating running error sum.
// ----------------------------------------------------------------------------
// One coefficient is in work at a time. After the input transfer the block
// tests the coefficient against the bounds and against the previous output
// (threshold half the quantizer step); a coefficient that fails goes straight
// out unchanged and the next input transfer waits until it has left. A
// coefficient that passes makes four passes through one shared multiply-add
// unit (times reciprocal, times step, times weight, times one minus weight),
// and the next input transfer waits until it is finished. The result sits
// in an output register; the block finishes the next item while it waits but
// holds that item until the register is taken. Configuration is a plain
// write port, index 0..5 in the order step, reciprocal, offset, weight,
// lower bound, upper bound; other indexes are ignored. pass_start clears the
// error sum ahead of its coefficient but keeps the previous coefficient.
// ----------------------------------------------------------------------------
module dct_coef_requantizer_top (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // configuration writes
    input  logic                                    i_cfg_we,
    input  logic [dcr_pkg::CFG_IDX_WIDTH-1:0]       i_cfg_index,
    input  logic [dcr_pkg::CFG_DATA_WIDTH-1:0]      i_cfg_data,
    // coefficient input
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic signed [dcr_pkg::COEF_WIDTH-1:0]   i_coef_in,
    input  logic                                    i_pass_start,
    // result output
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [dcr_pkg::COEF_WIDTH-1:0]   o_coef_out,
    output logic [dcr_pkg::ERR_WIDTH-1:0]           o_coef_error,
    output logic                                    o_was_changed,
    output logic [dcr_pkg::ACC_WIDTH-1:0]           o_error_sum
);
    import dcr_pkg::*;

    // configuration registers
    logic [QS_WIDTH-1:0]         r_quant_step;
    logic [INV_WIDTH-1:0]        r_inv_step;
    logic [OFS_WIDTH-1:0]        r_round_offset;
    logic [WGT_WIDTH-1:0]        r_blend_weight;
    logic signed [BND_WIDTH-1:0] r_lower_bound;
    logic signed [BND_WIDTH-1:0] r_upper_bound;

    // sequencer and working registers
    t_state                       r_state, n_state;
    t_ctrl                        ctrl;
    logic signed [COEF_WIDTH-1:0] r_coef;
    logic                         r_pass;
    logic                         r_changed;
    t_sum                         r_acc;
    logic [ERR_WIDTH-1:0]         r_err;
    logic [ACC_WIDTH-1:0]         r_err_sum;
    logic signed [COEF_WIDTH-1:0] r_prev;

    // output register
    logic                         r_out_valid;
    logic signed [COEF_WIDTH-1:0] r_coef_out;
    logic [ERR_WIDTH-1:0]         r_coef_error;
    logic                         r_was_changed;
    logic [ACC_WIDTH-1:0]         r_error_sum;

    // shared unit operands
    logic signed [MA_WIDTH-1:0]   mul_a;
    logic signed [MB_WIDTH-1:0]   mul_b;
    t_sum                         mul_add;
    t_sum                         mac_sum;

    // combinational helpers
    logic                         in_xfer;
    logic                         out_free;
    logic signed [SOFS_WIDTH-1:0] sofs;
    logic [WGT_WIDTH-1:0]         w_eff;
    logic [WGT_WIDTH-1:0]         w_inv;
    logic signed [MA_WIDTH-1:0]   t1;
    logic signed [MA_WIDTH-1:0]   t2;
    t_sum                         r_full;
    t_sum                         sat_hi;
    t_sum                         sat_lo;
    logic signed [COEF_WIDTH-1:0] res_sat;
    logic signed [COEF_WIDTH-1:0] res;
    logic signed [COEF_WIDTH:0]   cdiff;
    logic [COEF_WIDTH:0]          cabs;
    logic                         over_thr;
    logic signed [CMP_WIDTH-1:0]  c_x, lo_x, hi_x;
    logic                         in_range;
    logic                         changed;
    logic signed [MA_WIDTH:0]     ediff;
    logic [MA_WIDTH:0]            eabs;
    logic [ERR_WIDTH-1:0]         err_sat;
    logic [ACC_WIDTH:0]           sum_ext;
    logic [ACC_WIDTH-1:0]         sum_next;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // configuration writes, indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quant_step   <= QUANT_STEP_RST;
            r_inv_step     <= INV_STEP_RST;
            r_round_offset <= ROUND_OFFSET_RST;
            r_blend_weight <= BLEND_WEIGHT_RST;
            r_lower_bound  <= LOWER_BOUND_RST;
            r_upper_bound  <= UPPER_BOUND_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_QUANT_STEP:   r_quant_step   <= i_cfg_data[QS_WIDTH-1:0];
                CFG_INV_STEP:     r_inv_step     <= i_cfg_data[INV_WIDTH-1:0];
                CFG_ROUND_OFFSET: r_round_offset <= i_cfg_data[OFS_WIDTH-1:0];
                CFG_BLEND_WEIGHT: r_blend_weight <= i_cfg_data[WGT_WIDTH-1:0];
                CFG_LOWER_BOUND:  r_lower_bound  <= i_cfg_data[BND_WIDTH-1:0];
                CFG_UPPER_BOUND:  r_upper_bound  <= i_cfg_data[BND_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    // offset signed like the original, weight capped at one
    always_comb begin
        sofs  = r_coef[COEF_WIDTH-1] ? -$signed({2'b00, r_round_offset})
                                     : $signed({2'b00, r_round_offset});
        w_eff = (r_blend_weight > WEIGHT_ONE) ? WEIGHT_ONE : r_blend_weight;
        w_inv = WEIGHT_ONE - w_eff;
    end

    // threshold and bounds test against the previous output
    always_comb begin
        cdiff    = $signed({r_coef[COEF_WIDTH-1], r_coef})
                   - $signed({r_prev[COEF_WIDTH-1], r_prev});
        cabs     = cdiff[COEF_WIDTH] ? (COEF_WIDTH + 1)'(0) - cdiff : cdiff;
        over_thr = {cabs, 9'b0} > (COEF_WIDTH + 10)'(r_quant_step);
        c_x      = CMP_WIDTH'(r_coef);
        lo_x     = CMP_WIDTH'(r_lower_bound);
        hi_x     = CMP_WIDTH'(r_upper_bound);
        in_range = (c_x >= lo_x) && (c_x <= hi_x);
        changed  = over_thr && in_range;
    end

    // intermediate values taken back out of the accumulator
    always_comb begin
        t1     = MA_WIDTH'(tz_shr(r_acc, SHIFT_RECIP));
        t2     = MA_WIDTH'(tz_shr(r_acc, SHIFT_Q8));
        r_full = tz_shr(r_acc, SHIFT_Q8);
    end

    // absolute error of the requantized value, capped at 16 bits
    always_comb begin
        ediff   = $signed({t2[MA_WIDTH-1], t2}) - (MA_WIDTH + 1)'(r_coef);
        eabs    = ediff[MA_WIDTH] ? (MA_WIDTH + 1)'(0) - ediff : ediff;
        err_sat = (|eabs[MA_WIDTH:ERR_WIDTH]) ? {ERR_WIDTH{1'b1}} : eabs[ERR_WIDTH-1:0];
    end

    // error sum sticks at all ones
    always_comb begin
        sum_ext  = {1'b0, r_err_sum} + (ACC_WIDTH + 1)'(r_err);
        sum_next = sum_ext[ACC_WIDTH] ? {ACC_WIDTH{1'b1}} : sum_ext[ACC_WIDTH-1:0];
    end

    // final blend result, saturated to the coefficient range
    always_comb begin
        sat_hi = SUM_WIDTH'({(COEF_WIDTH-1){1'b1}});
        sat_lo = ~sat_hi;
        if (r_full > sat_hi) begin
            res_sat = COEF_WIDTH'(sat_hi);
        end else if (r_full < sat_lo) begin
            res_sat = COEF_WIDTH'(sat_lo);
        end else begin
            res_sat = COEF_WIDTH'(r_full);
        end
        res = r_changed ? res_sat : r_coef;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (in_xfer) n_state = ST_TEST;
            ST_TEST: n_state = changed ? ST_MUL1 : ST_DONE;
            ST_MUL1: n_state = ST_MUL2;
            ST_MUL2: n_state = ST_MUL3;
            ST_MUL3: n_state = ST_MUL4;
            ST_MUL4: n_state = ST_DONE;
            ST_DONE: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs: operand selection and load strobes
    always_comb begin
        ctrl       = '0;
        mul_a      = '0;
        mul_b      = '0;
        mul_add    = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            // no transfer while reset is held
            ST_IDLE: o_in_stall = !i_rst_n;
            ST_TEST: ctrl.test = 1'b1;
            // c * inv_step + s*d*256
            ST_MUL1: begin
                ctrl.ld_acc = 1'b1;
                mul_a       = MA_WIDTH'(r_coef);
                mul_b       = $signed(MB_WIDTH'(r_inv_step));
                mul_add     = SUM_WIDTH'(sofs) <<< 8;
            end
            // t1 * quant_step + s*d
            ST_MUL2: begin
                ctrl.ld_acc = 1'b1;
                mul_a       = t1;
                mul_b       = $signed(MB_WIDTH'(r_quant_step));
                mul_add     = SUM_WIDTH'(sofs);
            end
            // t2 * w, error taken from t2 in the same cycle
            ST_MUL3: begin
                ctrl.ld_acc = 1'b1;
                ctrl.ld_err = 1'b1;
                mul_a       = t2;
                mul_b       = $signed(MB_WIDTH'(w_eff));
            end
            // + c * (1 - w) + s*d
            ST_MUL4: begin
                ctrl.ld_acc = 1'b1;
                ctrl.ld_sum = 1'b1;
                mul_a       = MA_WIDTH'(r_coef);
                mul_b       = $signed(MB_WIDTH'(w_inv));
                mul_add     = r_acc + SUM_WIDTH'(sofs);
            end
            ST_DONE: ctrl.ld_out = out_free;
            default: begin
            end
        endcase
    end

    dcr_mac u_mac (
        .i_a      (mul_a),
        .i_b      (mul_b),
        .i_addend (mul_add),
        .o_sum    (mac_sum)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_prev      <= '0;
            r_err_sum   <= '0;
        end else begin
            r_state <= n_state;
            if (ctrl.ld_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (ctrl.ld_out) begin
                r_prev <= res;
            end
            if (ctrl.test && r_pass) begin
                r_err_sum <= '0;
            end else if (ctrl.ld_sum) begin
                r_err_sum <= sum_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_coef <= i_coef_in;
            r_pass <= i_pass_start;
        end
        if (ctrl.test) begin
            r_changed <= changed;
        end
        if (ctrl.test || ctrl.ld_err) begin
            r_err <= ctrl.ld_err ? err_sat : '0;
        end
        if (ctrl.ld_acc) begin
            r_acc <= mac_sum;
        end
        if (ctrl.ld_out) begin
            r_coef_out    <= res;
            r_coef_error  <= r_err;
            r_was_changed <= r_changed;
            r_error_sum   <= r_err_sum;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_coef_out    = r_coef_out;
    assign o_coef_error  = r_coef_error;
    assign o_was_changed = r_was_changed;
    assign o_error_sum   = r_error_sum;

endmodule

// ===== rtl/dcr_checker.sv =====
// ----------------------------------------------------------------------------
// dcr_checker
// Port-level checks for the coefficient requantizer, bound to the top level.
// ----------------------------------------------------------------------------
module dcr_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  o_in_stall,
    input logic                                  o_out_valid,
    input logic                                  i_out_stall,
    input logic signed [dcr_pkg::COEF_WIDTH-1:0] o_coef_out,
    input logic [dcr_pkg::ERR_WIDTH-1:0]         o_coef_error,
    input logic                                  o_was_changed,
    input logic [dcr_pkg::ACC_WIDTH-1:0]         o_error_sum
);
    import dcr_pkg::*;

    // one coefficient in work at a time
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while a coefficient is in work");

    // a new result appears only out of a busy cycle
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a coefficient in work");

    // an unchanged coefficient carries no error
    a_unchanged_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_was_changed) |-> (o_coef_error == '0))
        else $error("error reported for an unchanged coefficient");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_coef_out) && $stable(o_coef_error)
             && $stable(o_was_changed) && $stable(o_error_sum)))
        else $error("stalled result changed");

endmodule

bind dct_coef_requantizer_top dcr_checker u_dcr_checker (.*);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the coefficient requantizer: drives coefficients
// through valid/stall transfers, predicts every result in fixed point and
// checks each output transfer in order, across several register settings,
// both idling patterns and a long output hold-off
// ----------------------------------------------------------------------------
module tb_top;

    import dcr_pkg::*;

    // cycles to let the block settle once the last result is taken
    localparam int DRAIN_CYCLES    = 16;
    // length of the long output hold-off in the back-pressure test
    localparam int HOLD_OFF_CYCLES = 400;
    // register indexes that decode to nothing
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_IDX_SPARE_HI = 3'd7;

    // one expected output transfer
    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] coef;
        logic [ERR_WIDTH-1:0]         err;
        logic                         changed;
        logic [ACC_WIDTH-1:0]         sum;
    } t_coef_result;

    // input ports, all at known values from time zero
    logic                         i_clk         = 1'b0;
    logic                         i_rst_n       = 1'b0;
    logic                         i_cfg_we      = 1'b0;
    logic [CFG_IDX_WIDTH-1:0]     i_cfg_index   = '0;
    logic [CFG_DATA_WIDTH-1:0]    i_cfg_data    = '0;
    logic                         i_in_valid    = 1'b0;
    logic                         o_in_stall;
    logic signed [COEF_WIDTH-1:0] i_coef_in     = '0;
    logic                         i_pass_start  = 1'b0;
    logic                         o_out_valid;
    logic                         i_out_stall   = 1'b0;
    logic signed [COEF_WIDTH-1:0] o_coef_out;
    logic [ERR_WIDTH-1:0]         o_coef_error;
    logic                         o_was_changed;
    logic [ACC_WIDTH-1:0]         o_error_sum;

    // bench copy of the registers
    logic [QS_WIDTH-1:0]          mdl_step   = QUANT_STEP_RST;
    logic [INV_WIDTH-1:0]         mdl_inv    = INV_STEP_RST;
    logic [OFS_WIDTH-1:0]         mdl_offset = ROUND_OFFSET_RST;
    logic [WGT_WIDTH-1:0]         mdl_weight = BLEND_WEIGHT_RST;
    logic signed [BND_WIDTH-1:0]  mdl_lower  = LOWER_BOUND_RST;
    logic signed [BND_WIDTH-1:0]  mdl_upper  = UPPER_BOUND_RST;
    // bench copy of the block state
    logic signed [COEF_WIDTH-1:0] mdl_prev    = '0;
    logic [ACC_WIDTH-1:0]         mdl_err_sum = '0;

    // results predicted but not yet seen, oldest first
    t_coef_result coef_expect_q[$];

    // idling percentages of the two sides
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    // request and cycles left of a forced output hold-off
    logic        hold_off_start = 1'b0;
    int unsigned hold_off_left  = 0;

    int unsigned mismatch_count = 0;
    int unsigned n_sent         = 0;
    int unsigned n_checked      = 0;
    int unsigned n_changed      = 0;
    int unsigned n_pass_start   = 0;
    int unsigned n_cfg_writes   = 0;

    dct_coef_requantizer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_coef_in     (i_coef_in),
        .i_pass_start  (i_pass_start),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_coef_out    (o_coef_out),
        .o_coef_error  (o_coef_error),
        .o_was_changed (o_was_changed),
        .o_error_sum   (o_error_sum)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // shift right that drops fraction bits toward zero
    function automatic longint shr_toward_zero(input longint x, input int unsigned sh);
        if (x < 0) begin
            return -((-x) >>> sh);
        end
        return x >>> sh;
    endfunction

    // works out one result and advances the bench state
    function automatic t_coef_result requant_predict(
        input logic signed [COEF_WIDTH-1:0] coef,
        input logic                         clr
    );
        longint            c, lo, hi, d, w, sd, delta, t1, t2, e, r;
        longint unsigned   err, acc, acc_max;
        t_coef_result      res;
        c   = longint'(coef);
        lo  = longint'(mdl_lower);
        hi  = longint'(mdl_upper);
        d   = longint'(mdl_offset);
        // weight above unity acts as unity
        w   = (mdl_weight > WEIGHT_ONE) ? 256 : longint'(mdl_weight);
        // rounding offset takes the sign of the original
        sd  = (c < 0) ? -d : d;
        r   = c;
        err = 0;
        acc_max = (64'd1 << ACC_WIDTH) - 64'd1;
        if (clr) begin
            mdl_err_sum = '0;
        end
        delta = c - longint'(mdl_prev);
        if (delta < 0) begin
            delta = -delta;
        end
        // threshold is half the step, bounds inclusive
        res.changed = (delta * 512 > longint'(mdl_step)) && (c >= lo) && (c <= hi);
        if (res.changed) begin
            t1  = shr_toward_zero(c * longint'(mdl_inv) + sd * 256, 16);
            t2  = shr_toward_zero(t1 * longint'(mdl_step) + sd, 8);
            e   = t2 - c;
            if (e < 0) begin
                e = -e;
            end
            err = (e > 65535) ? 64'd65535 : longint'(e);
            r   = shr_toward_zero(t2 * w + c * (256 - w) + sd, 8);
            if (r > 32767) begin
                r = 32767;
            end
            if (r < -32768) begin
                r = -32768;
            end
            // error sum sticks at all ones
            acc = longint'(mdl_err_sum);
            mdl_err_sum = (acc_max - acc < err) ? acc_max[ACC_WIDTH-1:0]
                                                : ACC_WIDTH'(acc + err);
        end
        mdl_prev = r[COEF_WIDTH-1:0];
        res.coef = r[COEF_WIDTH-1:0];
        res.err  = err[ERR_WIDTH-1:0];
        res.sum  = mdl_err_sum;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------------

    // one register write, with the enable dropped again before the task returns
    // so enables never toggle twice in one step
    task automatic cfg_write(input logic [CFG_IDX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_QUANT_STEP:   mdl_step   = data[QS_WIDTH-1:0];
            CFG_INV_STEP:     mdl_inv    = data[INV_WIDTH-1:0];
            CFG_ROUND_OFFSET: mdl_offset = data[OFS_WIDTH-1:0];
            CFG_BLEND_WEIGHT: mdl_weight = data[WGT_WIDTH-1:0];
            CFG_LOWER_BOUND:  mdl_lower  = data[BND_WIDTH-1:0];
            CFG_UPPER_BOUND:  mdl_upper  = data[BND_WIDTH-1:0];
            default: ;
        endcase
        n_cfg_writes++;
        @(posedge i_clk);
    endtask

    // offers one coefficient, returns in the step of its transfer with
    // valid still high so back-to-back items keep it up
    task automatic send_coef(input logic signed [COEF_WIDTH-1:0] coef, input logic clr);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_coef_in    <= coef;
        i_pass_start <= clr;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        coef_expect_q.push_back(requant_predict(coef, clr));
        n_sent++;
        if (clr) begin
            n_pass_start++;
        end
    endtask

    // drops valid, waits for every result and lets the block settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (coef_expect_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // coefficient mix: full range, near the previous output (threshold
    // edge), extremes, near the bounds and small values
    function automatic logic signed [COEF_WIDTH-1:0] rand_coef();
        int span, v;
        span = int'(mdl_step >> 9) + 2;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = int'($urandom_range(0, 65535)) - 32768;
            4, 5:       v = int'(mdl_prev) + int'($urandom_range(0, 2 * span)) - span;
            6:          v = $urandom_range(0, 1) ? 32767 : -32768;
            7:          v = ($urandom_range(0, 1) ? int'(mdl_lower) : int'(mdl_upper))
                            + int'($urandom_range(0, 4)) - 2;
            default:    v = int'($urandom_range(0, 600)) - 300;
        endcase
        if (v > 32767) begin
            v = 32767;
        end
        if (v < -32768) begin
            v = -32768;
        end
        return v[COEF_WIDTH-1:0];
    endfunction

    // writes all six registers with a fresh random setting
    task automatic pick_random_config();
        int unsigned step, recip, ofs, wgt;
        int          lo, hi;
        case ($urandom_range(0, 4))
            0:       step = $urandom_range(1, 255);
            1:       step = $urandom_range(256, 4095);
            2:       step = $urandom_range(1, 65535);
            3:       step = 1;
            default: step = 65535;
        endcase
        // mostly a sensible reciprocal with a little error, sometimes junk
        if ($urandom_range(0, 3) == 0) begin
            recip = $urandom_range(0, 16777215);
        end else begin
            recip = 32'd16777216 / step + $urandom_range(0, 8) - 4;
            if (recip > 16777215) begin
                recip = 16777215;
            end
        end
        ofs = ($urandom_range(0, 4) == 0) ? $urandom_range(257, 511) : $urandom_range(0, 256);
        wgt = ($urandom_range(0, 4) == 0) ? $urandom_range(257, 511) : $urandom_range(0, 256);
        case ($urandom_range(0, 3))
            0, 1: begin
                lo = -65536;
                hi = 65535;
            end
            2: begin
                lo = int'($urandom_range(0, 131071)) - 65536;
                hi = int'($urandom_range(0, 131071)) - 65536;
            end
            default: begin
                lo = -int'($urandom_range(0, 40000));
                hi = int'($urandom_range(0, 40000));
            end
        endcase
        cfg_write(CFG_QUANT_STEP, CFG_DATA_WIDTH'(step));
        cfg_write(CFG_INV_STEP, CFG_DATA_WIDTH'(recip));
        cfg_write(CFG_ROUND_OFFSET, CFG_DATA_WIDTH'(ofs));
        cfg_write(CFG_BLEND_WEIGHT, CFG_DATA_WIDTH'(wgt));
        cfg_write(CFG_LOWER_BOUND, CFG_DATA_WIDTH'(lo));
        cfg_write(CFG_UPPER_BOUND, CFG_DATA_WIDTH'(hi));
    endtask

    // ------------------------------------------------------------------------
    // output side: hold-off counter, stall driver and result check
    // ------------------------------------------------------------------------

    always @(posedge i_clk) begin : hold_off_counter
        if (hold_off_start) begin
            hold_off_left <= HOLD_OFF_CYCLES;
        end else if (hold_off_left != 0) begin
            hold_off_left <= hold_off_left - 1;
        end
    end

    always @(posedge i_clk) begin : out_stall_driver
        i_out_stall <= (hold_off_left != 0) || ($urandom_range(0, 99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin : result_check
        t_coef_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (coef_expect_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result transfer: coef %0d err %0d changed %0b sum %0d",
                             o_coef_out, o_coef_error, o_was_changed, o_error_sum);
                end
            end else begin
                want = coef_expect_q.pop_front();
                if (o_coef_out !== want.coef || o_coef_error !== want.err ||
                    o_was_changed !== want.changed || o_error_sum !== want.sum) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("result %0d wrong: want coef %0d err %0d chg %0b sum %0d",
                                 n_checked, $signed(want.coef), want.err, want.changed,
                                 want.sum);
                        $display("                  got  coef %0d err %0d chg %0b sum %0d",
                                 o_coef_out, o_coef_error, o_was_changed, o_error_sum);
                    end
                end
                if (want.changed) begin
                    n_changed++;
                end
                n_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset register values, coefficient extremes and a pass start
    task automatic test_reset_values();
        send_coef(16'sd0, 1'b1);
        send_coef(16'sd32767, 1'b0);
        send_coef(-16'sd32768, 1'b0);
        send_coef(-16'sd1, 1'b0);
        send_coef(16'sd1, 1'b0);
        send_coef(16'sd300, 1'b1);
        wait_idle();
    endtask

    // zero step: threshold test reduces to any nonzero difference
    task automatic test_zero_step();
        cfg_write(CFG_QUANT_STEP, 24'd0);
        cfg_write(CFG_INV_STEP, 24'hFFFFFF);
        send_coef(16'sd5, 1'b0);
        send_coef(16'sd5, 1'b0);
        send_coef(-16'sd7, 1'b0);
        wait_idle();
    endtask

    // weight above unity clamps, offset above unity is used as is, weight zero
    task automatic test_weight_and_offset_limits();
        cfg_write(CFG_QUANT_STEP, 24'd1000);
        cfg_write(CFG_INV_STEP, 24'd16777);
        cfg_write(CFG_ROUND_OFFSET, 24'd511);
        cfg_write(CFG_BLEND_WEIGHT, 24'd511);
        send_coef(16'sd1000, 1'b0);
        send_coef(-16'sd1000, 1'b0);
        wait_idle();
        cfg_write(CFG_ROUND_OFFSET, 24'd0);
        cfg_write(CFG_BLEND_WEIGHT, 24'd0);
        send_coef(16'sd12345, 1'b0);
        send_coef(-16'sd12345, 1'b0);
        wait_idle();
    endtask

    // inverted bounds change nothing, a single-point window, widest bounds
    task automatic test_bounds();
        cfg_write(CFG_ROUND_OFFSET, 24'd128);
        cfg_write(CFG_BLEND_WEIGHT, 24'd256);
        cfg_write(CFG_LOWER_BOUND, 24'sd100);
        cfg_write(CFG_UPPER_BOUND, -24'sd100);
        send_coef(16'sd0, 1'b0);
        send_coef(-16'sd4000, 1'b0);
        wait_idle();
        cfg_write(CFG_LOWER_BOUND, 24'sd500);
        cfg_write(CFG_UPPER_BOUND, 24'sd500);
        send_coef(16'sd500, 1'b0);
        send_coef(16'sd501, 1'b0);
        wait_idle();
        cfg_write(CFG_LOWER_BOUND, -24'sd65536);
        cfg_write(CFG_UPPER_BOUND, 24'sd65535);
    endtask

    // writes to undecoded indexes must leave every register alone
    task automatic test_ignored_index();
        cfg_write(CFG_IDX_SPARE_LO, 24'h000001);
        cfg_write(CFG_IDX_SPARE_HI, 24'hFFFFFF);
        send_coef(16'sd2, 1'b1);
        send_coef(-16'sd20000, 1'b0);
        wait_idle();
    endtask

    // largest step and reciprocal drive the result into saturation
    task automatic test_saturation();
        cfg_write(CFG_QUANT_STEP, 24'h00FFFF);
        cfg_write(CFG_INV_STEP, 24'hFFFFFF);
        cfg_write(CFG_ROUND_OFFSET, 24'd256);
        send_coef(16'sd32767, 1'b0);
        send_coef(-16'sd32768, 1'b0);
        wait_idle();
    endtask

    // random items in chunks, each chunk under a fresh setting
    task automatic test_random_traffic(input int unsigned n_items,
                                       input int unsigned snd_pct,
                                       input int unsigned rcv_pct);
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        for (int unsigned i = 0; i < n_items; i++) begin
            if (i % 100 == 0) begin
                wait_idle();
                pick_random_config();
            end
            send_coef(rand_coef(), ($urandom_range(0, 31) == 0));
        end
        wait_idle();
    endtask

    // receiver holds off for a long stretch while the sender keeps going,
    // so the output register fills and the input stalls
    task automatic test_output_hold_off();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        cfg_write(CFG_QUANT_STEP, 24'd256);
        cfg_write(CFG_INV_STEP, 24'd65536);
        cfg_write(CFG_LOWER_BOUND, -24'sd65536);
        cfg_write(CFG_UPPER_BOUND, 24'sd65535);
        hold_off_start <= 1'b1;
        @(posedge i_clk);
        hold_off_start <= 1'b0;
        for (int i = 0; i < 40; i++) begin
            send_coef(rand_coef(), (i == 0));
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------

    initial begin : main_sequence
        // synchronous reset
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 22;
        recv_idle_pct = 75;
        test_reset_values();
        test_zero_step();
        test_weight_and_offset_limits();
        test_bounds();
        test_ignored_index();
        test_saturation();

        test_random_traffic(400, 22, 75);
        test_random_traffic(400, 75, 22);
        test_random_traffic(300, 0, 0);
        test_output_hold_off();

        $display("sent %0d coefficients (%0d pass starts), checked %0d results, %0d changed",
                 n_sent, n_pass_start, n_checked, n_changed);
        $display("%0d register writes over directed corners and random settings, %0d mismatches",
                 n_cfg_writes, mismatch_count);
        if (mismatch_count == 0 && coef_expect_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // hang guard, far above the slowest legal run
    initial begin : run_limit
        #400000;
        $display("timeout with %0d results outstanding", coef_expect_q.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
